// ===== hw/rtl/bbsf_pkg.sv =====
package bbsf_pkg;

    localparam int CAP_W    = 11;
    localparam int FUNC_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int TOTAL_W  = 64;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 168;

    localparam logic [FUNC_W-1:0] FUNC_PUSH   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_CLOSE  = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_STATUS = 2'd3;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;  // latch the incoming transaction
        logic exec;     // apply the request to the buffer state
        logic load;     // fill the result register
    } cmd_t;

endpackage

// ===== hw/rtl/bbsf_ram.sv =====
module bbsf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/bbsf_ctrl.sv =====
module bbsf_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    output logic          m_tvalid,
    input  logic          m_tready,
    output bbsf_pkg::cmd_t cmd
);

    import bbsf_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_LOAD = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic       load;

    // The result register can take a new value once its old one is gone
    assign load = (state_reg == ST_LOAD) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: state_next = ST_READ;
            ST_READ: state_next = ST_LOAD;
            ST_LOAD: begin
                if (load) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready    = (state_reg == ST_IDLE);
    assign m_tvalid    = m_tvalid_reg;
    assign cmd.capture = (state_reg == ST_IDLE) && s_tvalid;
    assign cmd.exec    = (state_reg == ST_EXEC);
    assign cmd.load    = load;

endmodule

// ===== hw/rtl/bbsf_datapath.sv =====
module bbsf_datapath #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  bbsf_pkg::cmd_t                  cmd,
    input  logic [bbsf_pkg::FUNC_W-1:0]     func,
    input  logic [bbsf_pkg::BYTE_W-1:0]     data_byte,
    input  logic [bbsf_pkg::CAP_W-1:0]      pop_count,
    input  logic [bbsf_pkg::CAP_W-1:0]      capacity_limit,
    output logic                            ram_we,
    output logic [AW-1:0]                   ram_waddr,
    output logic [bbsf_pkg::BYTE_W-1:0]     ram_wdata,
    output logic [AW-1:0]                   ram_raddr,
    input  logic [bbsf_pkg::BYTE_W-1:0]     ram_rdata,
    output logic [bbsf_pkg::M_DATA_W-1:0]   m_tdata
);

    import bbsf_pkg::*;

    localparam int SW = ((AW > CAP_W) ? AW : CAP_W) + 1;
    localparam int DepthCap = (DEPTH > 2047) ? 2047 : DEPTH;
    localparam logic [CAP_W-1:0] DEPTH_CAP = CAP_W'(DepthCap);
    localparam logic [SW-1:0]    DEPTH_S   = SW'(DEPTH);

    logic [FUNC_W-1:0]   func_reg;
    logic [BYTE_W-1:0]   byte_reg;
    logic [CAP_W-1:0]    count_reg;
    logic                accepted_reg;

    logic [AW-1:0]       head_reg, head_next;
    logic [CAP_W-1:0]    fill_reg, fill_next;
    logic [TOTAL_W-1:0]  pushed_reg, pushed_next;
    logic [TOTAL_W-1:0]  popped_reg, popped_next;
    logic                closed_reg, closed_next;
    logic                error_reg, error_next;
    logic                accepted_next;

    logic [CAP_W-1:0]    cap_eff;
    logic [SW-1:0]       addend;
    logic [SW-1:0]       sum;
    logic [SW-1:0]       wrapped;
    logic                push_ok;
    logic [CAP_W-1:0]    avail;
    logic [M_DATA_W-1:0] m_tdata_reg;

    assign cap_eff = (capacity_limit > DEPTH_CAP) ? DEPTH_CAP : capacity_limit;
    assign push_ok = (func_reg == FUNC_PUSH) && (fill_reg < cap_eff);

    // Tail slot for a push, new head for a pop within the fill; both stay below twice the depth
    assign addend  = (func_reg == FUNC_PUSH) ? SW'(fill_reg) : SW'(count_reg);
    assign sum     = SW'(head_reg) + addend;
    assign wrapped = (sum >= DEPTH_S) ? (sum - DEPTH_S) : sum;

    assign ram_we    = cmd.exec && push_ok;
    assign ram_waddr = wrapped[AW-1:0];
    assign ram_wdata = byte_reg;
    assign ram_raddr = head_reg;

    always_comb begin
        head_next     = head_reg;
        fill_next     = fill_reg;
        pushed_next   = pushed_reg;
        popped_next   = popped_reg;
        closed_next   = closed_reg;
        error_next    = error_reg;
        accepted_next = accepted_reg;
        if (cmd.exec) begin
            accepted_next = 1'b0;
            unique case (func_reg)
                FUNC_PUSH: begin
                    if (push_ok) begin
                        fill_next     = fill_reg + CAP_W'(1);
                        pushed_next   = pushed_reg + TOTAL_W'(1);
                        accepted_next = 1'b1;
                    end
                end
                FUNC_POP: begin
                    if (count_reg > fill_reg) begin
                        error_next = 1'b1;
                    end else begin
                        head_next     = wrapped[AW-1:0];
                        fill_next     = fill_reg - count_reg;
                        popped_next   = popped_reg + TOTAL_W'(count_reg);
                        accepted_next = 1'b1;
                    end
                end
                FUNC_CLOSE: closed_next = 1'b1;
                FUNC_STATUS: ;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg   <= '0;
            fill_reg   <= '0;
            pushed_reg <= '0;
            popped_reg <= '0;
            closed_reg <= 1'b0;
            error_reg  <= 1'b0;
        end else begin
            head_reg   <= head_next;
            fill_reg   <= fill_next;
            pushed_reg <= pushed_next;
            popped_reg <= popped_next;
            closed_reg <= closed_next;
            error_reg  <= error_next;
        end
    end

    always_ff @(posedge aclk) begin
        accepted_reg <= accepted_next;
        if (cmd.capture) begin
            func_reg  <= func;
            byte_reg  <= data_byte;
            count_reg <= pop_count;
        end
    end

    assign avail = (cap_eff > fill_reg) ? (cap_eff - fill_reg) : '0;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_tdata_reg <= {5'b0,
                            error_reg,
                            closed_reg && (fill_reg == '0),
                            closed_reg,
                            popped_reg,
                            pushed_reg,
                            avail,
                            fill_reg,
                            (fill_reg != '0) ? ram_rdata : {BYTE_W{1'b0}},
                            fill_reg != '0,
                            accepted_reg};
        end
    end

    assign m_tdata = m_tdata_reg;

endmodule

// ===== hw/rtl/bounded_byte_stream_fifo.sv =====
// Channel  | Ports                         | Contents
// ---------+-------------------------------+------------------------------------------
// request  | s_tvalid s_tready s_tdata     | tuser: func; tdata: data_byte, pop_count
//          | s_tuser                       |
// status   | m_tvalid m_tready m_tdata     | one status transaction per request
// config   | psel penable pwrite paddr     | capacity_limit at addresses 0 to 3
//          | pwdata prdata pready          |
//
// A request is taken in the idle step, then the state is updated and the store written,
// the store is read at the new head and the result is loaded, which makes the status valid;
// the next request is taken once the load step has returned the controller to idle.
// Reset (aresetn low, synchronous) empties the buffer and clears counters and flags;
// capacity_limit returns to 1024. The store itself is not cleared.
// A held status transaction stalls the next request only at its final load step.
module bounded_byte_stream_fifo #(
    parameter int DEPTH = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [7:0] data_byte, [18:8] pop_count, [23:19] zero
    input  logic [bbsf_pkg::S_DATA_W-1:0] s_tdata,
    // [1:0] func
    input  logic [bbsf_pkg::FUNC_W-1:0]   s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] accepted, [1] peek_valid, [9:2] peek_byte, [20:10] buffered,
    // [31:21] available, [95:32] pushed_total, [159:96] popped_total,
    // [160] closed, [161] finished, [162] error, [167:163] zero
    output logic [bbsf_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    import bbsf_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    cmd_t              cmd;
    logic [CAP_W-1:0]  cap_reg;
    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic [BYTE_W-1:0] ram_rdata;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = paddr[2] ? 32'd0 : {21'd0, cap_reg};

    bbsf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    bbsf_datapath #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .func           (s_tuser),
        .data_byte      (s_tdata[7:0]),
        .pop_count      (s_tdata[18:8]),
        .capacity_limit (cap_reg),
        .ram_we         (ram_we),
        .ram_waddr      (ram_waddr),
        .ram_wdata      (ram_wdata),
        .ram_raddr      (ram_raddr),
        .ram_rdata      (ram_rdata),
        .m_tdata        (m_tdata)
    );

    bbsf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

endmodule

// ===== dv/bbsf_checker.sv =====
module bbsf_checker #(
    parameter int         DEPTH    = 1024,
    parameter logic [2:0] CAP_ADDR = 3'd0
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // [7:0] data_byte, [18:8] pop_count, [23:19] zero
    input  logic [bbsf_pkg::S_DATA_W-1:0] s_tdata,
    // [1:0] func
    input  logic [bbsf_pkg::FUNC_W-1:0]   s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] accepted, [1] peek_valid, [9:2] peek_byte, [20:10] buffered,
    // [31:21] available, [95:32] pushed_total, [159:96] popped_total,
    // [160] closed, [161] finished, [162] error, [167:163] zero
    input  logic [bbsf_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    input  logic [31:0]                   prdata,
    input  logic                          pready,
    output int                            fail_count,
    output int                            pending,
    output int                            results_seen,
    output logic [bbsf_pkg::CAP_W-1:0]    fill_level
);
    timeunit 1ns;
    timeprecision 1ps;
    import bbsf_pkg::*;

    localparam int DUE_DEPTH = 16;

    // Layout of one status transaction, lowest field last
    typedef struct packed {
        logic [4:0]         pad;
        logic               error;
        logic               finished;
        logic               closed;
        logic [TOTAL_W-1:0] popped_total;
        logic [TOTAL_W-1:0] pushed_total;
        logic [CAP_W-1:0]   available;
        logic [CAP_W-1:0]   buffered;
        logic [BYTE_W-1:0]  peek_byte;
        logic               peek_valid;
        logic               accepted;
    } status_t;

    logic [BYTE_W-1:0]  byte_mem [DEPTH];
    int unsigned        head;
    logic [CAP_W-1:0]   fill;
    logic [TOTAL_W-1:0] n_pushed;
    logic [TOTAL_W-1:0] n_popped;
    logic               shadow_closed;
    logic               err_seen;
    logic [CAP_W-1:0]   cap_reg;
    status_t            due_ring [DUE_DEPTH];
    int                 due_rd = 0;
    int                 due_wr = 0;
    int                 due_cnt = 0;
    int                 mismatches = 0;
    int                 results_n = 0;

    // Apply one request to the shadow buffer and return the status it yields
    function automatic status_t next_status(logic [FUNC_W-1:0] func, logic [BYTE_W-1:0] data,
                                            logic [CAP_W-1:0] cnt);
        status_t     st;
        int unsigned cap;
        cap = (cap_reg > DEPTH) ? DEPTH : cap_reg;
        st = '0;
        case (func)
            FUNC_PUSH: begin
                if (fill < cap) begin
                    byte_mem[(head + fill) % DEPTH] = data;
                    fill = fill + 1'b1;
                    n_pushed = n_pushed + 1'b1;
                    st.accepted = 1'b1;
                end
            end
            FUNC_POP: begin
                if (cnt > fill) begin
                    err_seen = 1'b1;
                end else begin
                    head = (head + cnt) % DEPTH;
                    fill = fill - cnt;
                    n_popped = n_popped + cnt;
                    st.accepted = 1'b1;
                end
            end
            FUNC_CLOSE: begin
                shadow_closed = 1'b1;
            end
            default: ;
        endcase
        st.peek_valid   = (fill != 0);
        st.peek_byte    = (fill != 0) ? byte_mem[head] : 8'd0;
        st.buffered     = fill;
        st.available    = (cap > fill) ? CAP_W'(cap - fill) : '0;
        st.pushed_total = n_pushed;
        st.popped_total = n_popped;
        st.closed       = shadow_closed;
        st.finished     = shadow_closed && (fill == 0);
        st.error        = err_seen;
        return st;
    endfunction

    function automatic string show(status_t s);
        return $sformatf({"acc=%0b pv=%0b peek=%02h buf=%0d avail=%0d pushed=%0d popped=%0d",
                          " closed=%0b fin=%0b err=%0b pad=%0h"},
                         s.accepted, s.peek_valid, s.peek_byte, s.buffered, s.available,
                         s.pushed_total, s.popped_total, s.closed, s.finished, s.error, s.pad);
    endfunction

    function automatic string differing_fields(status_t want, status_t got);
        string s;
        s = "";
        if (got.accepted     !== want.accepted)     s = {s, " accepted"};
        if (got.peek_valid   !== want.peek_valid)   s = {s, " peek_valid"};
        if (got.peek_byte    !== want.peek_byte)    s = {s, " peek_byte"};
        if (got.buffered     !== want.buffered)     s = {s, " buffered"};
        if (got.available    !== want.available)    s = {s, " available"};
        if (got.pushed_total !== want.pushed_total) s = {s, " pushed_total"};
        if (got.popped_total !== want.popped_total) s = {s, " popped_total"};
        if (got.closed       !== want.closed)       s = {s, " closed"};
        if (got.finished     !== want.finished)     s = {s, " finished"};
        if (got.error        !== want.error)        s = {s, " error"};
        if (got.pad          !== want.pad)          s = {s, " pad"};
        return s;
    endfunction

    function automatic void note_mismatch(string msg);
        if (mismatches < 10) $display("%0t ns mismatch: %s", $realtime, msg);
        mismatches++;
    endfunction

    always @(posedge aclk) begin
        status_t got;
        status_t want;
        status_t fresh;
        string   diff;
        if (!aresetn) begin
            head          = 0;
            fill          = '0;
            n_pushed      = '0;
            n_popped      = '0;
            shadow_closed = 1'b0;
            err_seen      = 1'b0;
            cap_reg       = 11'd1024;
            due_rd        = 0;
            due_wr        = 0;
            due_cnt       = 0;
        end else begin
            // Compare first: a status leaving now belongs to an older request
            if (m_tvalid && m_tready) begin
                got = status_t'(m_tdata);
                results_n++;
                if (due_cnt == 0) begin
                    note_mismatch({"status with no request outstanding: ", show(got)});
                end else begin
                    want    = due_ring[due_rd];
                    due_rd  = (due_rd + 1) % DUE_DEPTH;
                    due_cnt--;
                    diff = differing_fields(want, got);
                    if (diff != "")
                        note_mismatch({"field(s)", diff, "\n  exp ", show(want),
                                       "\n  act ", show(got)});
                end
            end
            if (s_tvalid && s_tready) begin
                fresh = next_status(s_tuser, s_tdata[7:0], s_tdata[18:8]);
                if (due_cnt == DUE_DEPTH) begin
                    note_mismatch("too many requests outstanding");
                end else begin
                    due_ring[due_wr] = fresh;
                    due_wr  = (due_wr + 1) % DUE_DEPTH;
                    due_cnt++;
                end
            end
            if (psel && penable && pready && paddr == CAP_ADDR) begin
                if (pwrite)
                    cap_reg = pwdata[CAP_W-1:0];
                else if (prdata !== {21'd0, cap_reg})
                    note_mismatch($sformatf("capacity readback exp %0d act %0d",
                                            cap_reg, prdata));
            end
        end
        fill_level   <= fill;
        pending      <= due_cnt;
        fail_count   <= mismatches;
        results_seen <= results_n;
    end

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import bbsf_pkg::*;

    localparam int         DEPTH       = 1024;
    localparam logic [2:0] CAP_ADDR    = 3'd0;
    localparam int         HOLD_CYCLES = 300;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [FUNC_W-1:0]   s_tuser  = FUNC_STATUS;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [2:0]          paddr    = CAP_ADDR;
    logic [31:0]         pwdata   = '0;
    logic [31:0]         prdata;
    logic                pready;

    int                  fail_count;
    int                  pending;
    int                  results_seen;
    logic [CAP_W-1:0]    fill_level;

    int                  src_idle_pct  = 0;
    int                  snk_idle_pct  = 0;
    bit                  sink_hold     = 1'b0;
    int                  requests_sent = 0;
    int                  cap_writes    = 0;
    logic [CAP_W-1:0]    last_pop      = '0;

    bounded_byte_stream_fifo #(.DEPTH(DEPTH)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    bbsf_checker #(.DEPTH(DEPTH), .CAP_ADDR(CAP_ADDR)) status_chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .fail_count(fail_count), .pending(pending), .results_seen(results_seen),
        .fill_level(fill_level)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    // Status receiver: random stalls, plus one long hold-off on request
    initial begin
        while (!aresetn) @(posedge aclk);
        forever begin
            if (sink_hold) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                sink_hold = 1'b0;
            end else if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic offer_request(logic [FUNC_W-1:0] func, logic [BYTE_W-1:0] data,
                                 logic [CAP_W-1:0] cnt);
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {5'd0, cnt, data};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        requests_sent++;
        // The shadow fill does not yet include this transaction
        last_pop = (func == FUNC_POP) ? cnt : '0;
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= {5'd0, 19'($urandom)};
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        last_pop = '0;
    endtask

    task automatic apb_access(logic wr, logic [31:0] wdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= CAP_ADDR;
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_capacity(logic [31:0] value);
        wait_drained();
        apb_access(1'b1, value);
        apb_access(1'b0, '0);
        cap_writes++;
    endtask

    // Pops stay within the fill unless sticky flags are allowed in this phase
    task automatic random_request(int push_pct, int status_pct, bit sticky_ok);
        logic [FUNC_W-1:0] func;
        logic [CAP_W-1:0]  cnt;
        int                roll;
        int unsigned       bound;
        roll  = $urandom_range(0, 99);
        bound = (fill_level > last_pop) ? fill_level - last_pop : 0;
        cnt   = CAP_W'($urandom);
        if (roll < push_pct) begin
            func = FUNC_PUSH;
        end else if (roll < push_pct + status_pct) begin
            func = FUNC_STATUS;
        end else if (sticky_ok && roll >= 96) begin
            func = FUNC_CLOSE;
        end else begin
            func = FUNC_POP;
            if (sticky_ok)
                cnt = ($urandom_range(0, 9) == 0) ? cnt : CAP_W'($urandom_range(0, bound + 1));
            else if ($urandom_range(0, 3) == 0)
                cnt = CAP_W'($urandom_range(0, bound));
            else
                cnt = CAP_W'($urandom_range(0, (bound < 4) ? bound : 4));
        end
        offer_request(func, BYTE_W'($urandom), cnt);
    endtask

    initial begin
        int cap;
        int push_pct;
        int idle_pct;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Basic push, pop and status on the reset capacity
        src_idle_pct = 20;
        snk_idle_pct = 20;
        offer_request(FUNC_STATUS, 8'h00, 11'd0);
        offer_request(FUNC_POP,    8'hFF, 11'd0);
        offer_request(FUNC_PUSH,   8'h00, 11'h7FF);
        offer_request(FUNC_PUSH,   8'hFF, 11'd0);
        offer_request(FUNC_PUSH,   8'h5A, 11'h2AA);
        offer_request(FUNC_STATUS, 8'hFF, 11'h7FF);
        offer_request(FUNC_POP,    8'h00, 11'd0);
        offer_request(FUNC_POP,    8'h00, 11'd1);
        offer_request(FUNC_POP,    8'hA5, 11'd2);

        // Drop pushes at a small capacity
        set_capacity(2);
        offer_request(FUNC_PUSH,   8'h11, 11'd0);
        offer_request(FUNC_PUSH,   8'h22, 11'd0);
        offer_request(FUNC_PUSH,   8'h33, 11'd0);
        offer_request(FUNC_STATUS, 8'h00, 11'd0);

        // Lower the capacity under the fill: held bytes stay, pushes drop until pops bring the fill below it
        set_capacity(1);
        offer_request(FUNC_PUSH,   8'h44, 11'd0);
        offer_request(FUNC_POP,    8'h00, 11'd1);
        offer_request(FUNC_PUSH,   8'h55, 11'd0);
        offer_request(FUNC_POP,    8'h00, 11'd1);
        offer_request(FUNC_PUSH,   8'h66, 11'd0);

        // Capacity above the store depth acts as the depth
        set_capacity(2047);
        offer_request(FUNC_PUSH,   8'hC3, 11'd0);
        offer_request(FUNC_STATUS, 8'h00, 11'd0);
        offer_request(FUNC_POP,    8'h00, 11'd2);

        set_capacity(0);
        offer_request(FUNC_PUSH,   8'h96, 11'd0);
        offer_request(FUNC_POP,    8'h00, 11'd0);

        // Fill the whole store, starting under a long receiver hold-off, then drain it in two pops
        // so that the head wraps past the end of the store
        set_capacity(DEPTH);
        src_idle_pct = 0;
        snk_idle_pct = 10;
        sink_hold    = 1'b1;
        repeat (DEPTH + 1) offer_request(FUNC_PUSH, BYTE_W'($urandom), CAP_W'($urandom));
        offer_request(FUNC_POP,    BYTE_W'($urandom), CAP_W'(DEPTH - 24));
        offer_request(FUNC_POP,    BYTE_W'($urandom), CAP_W'(24));
        offer_request(FUNC_STATUS, BYTE_W'($urandom), CAP_W'($urandom));

        // Random traffic with the sticky flags still clear
        for (int p = 0; p < 6; p++) begin
            case (p)
                0:       begin cap = 7;    push_pct = 55; idle_pct = 0;  end
                1:       begin cap = 0;    push_pct = 40; idle_pct = 25; end
                2:       begin cap = 1024; push_pct = 60; idle_pct = 10; end
                3:       begin cap = 1025; push_pct = 50; idle_pct = 40; end
                4:       begin cap = 300;  push_pct = 75; idle_pct = 15; end
                default: begin cap = $urandom; push_pct = 50; idle_pct = 30; end
            endcase
            set_capacity(cap);
            src_idle_pct = idle_pct;
            snk_idle_pct = (p % 2 == 0) ? 30 - idle_pct / 2 : idle_pct;
            repeat (10) random_request(push_pct, 20, 1'b0);
        end

        // Over-long pops, close and push after close
        set_capacity(32);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        offer_request(FUNC_POP, BYTE_W'($urandom), 11'h7FF);
        wait_drained();
        offer_request(FUNC_POP,   BYTE_W'($urandom), fill_level + 1'b1);
        offer_request(FUNC_CLOSE, BYTE_W'($urandom), CAP_W'($urandom));
        offer_request(FUNC_PUSH,  8'hA5, CAP_W'($urandom));
        wait_drained();
        offer_request(FUNC_POP,    BYTE_W'($urandom), fill_level);
        offer_request(FUNC_STATUS, BYTE_W'($urandom), CAP_W'($urandom));

        // Closing stretch at full rate, over-long pops allowed
        set_capacity(16);
        repeat (30) random_request(45, 15, 1'b1);

        wait_drained();
        repeat (10) @(posedge aclk);
        $display("Run covered %0d requests, %0d status transactions, %0d capacity settings",
                 requests_sent, results_seen, cap_writes);
        $display("incl. full store, zero and above-depth capacity, over-long pops and close");
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
